// ----- hw/rtl/bhc_pkg.sv -----
// bhc_pkg: widths, register map, beat and state types and fixed-point
// constants for the boost hysteresis controller. No dependencies.
package bhc_pkg;

  // Field widths
  localparam int LOAD_W  = 16;
  localparam int ID_W    = 22;
  localparam int LEVEL_W = 16;
  localparam int KHZ_W   = 24;
  localparam int THR_W   = 14;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_THR_MAINS     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_BATTERY   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_FREQ      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MAX   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAINS_BOOST   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAINS_BASE    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_BASE  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KBD_PRESENT   = 4'd7;

  // Register reset values
  localparam logic [THR_W-1:0] THR_MAINS_RST   = 14'd900;
  localparam logic [THR_W-1:0] THR_BATTERY_RST = 14'd800;
  localparam logic [KHZ_W-1:0] MAINS_BOOST_RST = 24'd2600000;

  // Percentages, in whole percent of PCT_BASE
  localparam int PCT_BASE             = 100;
  localparam int DISPLAY_PERCENT      = 25;
  localparam int BATTERY_FREQ_PERCENT = 50;
  localparam int PCT_W                = $clog2(PCT_BASE + 1);

  localparam logic [PCT_W-1:0] DISPLAY_PCT = PCT_W'(DISPLAY_PERCENT);
  localparam logic [PCT_W-1:0] BATTERY_PCT = PCT_W'(BATTERY_FREQ_PERCENT);

  // floor(p / PCT_BASE) as (p * RECIP) >> RECIP_SHIFT, exact for p < 2**PROD_W
  localparam int PROD_W      = KHZ_W + PCT_W;
  localparam int RECIP_SHIFT = PROD_W + $clog2(PCT_BASE);
  localparam int RECIP_W     = PROD_W + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RECIP_SHIFT) + 64'(PCT_BASE - 1)) / 64'(PCT_BASE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int SCALED_W    = PROD_W + RECIP_W;

  // Exit hysteresis, tenths of a percent
  localparam logic [LOAD_W:0] HYST_TENTHS = 17'd100;

  typedef enum logic [1:0] {
    TR_NONE  = 2'd0,
    TR_ENTER = 2'd1,
    TR_LEAVE = 2'd2
  } trans_t;

  typedef struct packed {
    logic [LOAD_W-1:0]  focused_load;
    logic [ID_W-1:0]    focused_id;
    logic               on_mains;
    logic               boost_allowed;
    logic [LEVEL_W-1:0] display_level;
    logic               display_level_ok;
    logic [LEVEL_W-1:0] keyboard_level;
    logic               keyboard_level_ok;
    logic [KHZ_W-1:0]   current_cap_khz;
  } item_t;

  typedef struct packed {
    logic               boosted;
    trans_t             transition;
    logic               cap_write;
    logic [KHZ_W-1:0]   cap_khz;
    logic               keyboard_write;
    logic [LEVEL_W-1:0] keyboard_value;
    logic               display_write;
    logic [LEVEL_W-1:0] display_value;
    logic               display_dimmed;
  } result_t;

  typedef struct packed {
    logic               boost_on;
    logic               entered_on_mains;
    logic [ID_W-1:0]    boost_owner;
    logic [LEVEL_W-1:0] saved_display;
    logic               saved_display_ok;
    logic [LEVEL_W-1:0] saved_keyboard;
    logic               saved_keyboard_ok;
    logic               dim_active;
    logic [KHZ_W-1:0]   boost_cap_khz;
  } state_t;

  // Register file as seen by the tick logic, with the two derived values
  typedef struct packed {
    logic [THR_W-1:0]   threshold_mains;
    logic [THR_W-1:0]   threshold_battery;
    logic [LEVEL_W-1:0] display_max_level;
    logic [KHZ_W-1:0]   mains_boost_khz;
    logic [KHZ_W-1:0]   mains_baseline_khz;
    logic [KHZ_W-1:0]   battery_baseline_khz;
    logic               keyboard_present;
    logic [LEVEL_W-1:0] display_target;   // dim level, never below 1
    logic [KHZ_W-1:0]   battery_cap_khz;  // boost cap on battery
  } cfg_t;

endpackage

// ----- hw/rtl/boost_hysteresis_controller_core.sv -----
// boost_hysteresis_controller_core: top level. Input register, tick logic,
// controller state and result register. Uses bhc_pkg, bhc_cfg_regs, bhc_step.
//
//  channel  direction  handshake              beat
//  in       sink       in_valid / in_stall    one tick (load, id, power, levels, cap)
//  out      source     out_valid / out_stall  one result per tick
//  cfg      sink       cfg_valid / cfg_ready  register index and data, always ready
//
// A beat passes the input register, then the result register. One tick per
// cycle sustained while neither out_stall nor the scaler holds it, bounded by
// the controller state loop through bhc_step. A write to top_freq_khz or
// display_max_level runs the scaler; ticks already registered wait for it,
// holding the input stall. Synchronous active-high reset clears state and
// valids; config takes its defaults. A stalled result holds; the input
// register keeps taking beats until it also fills, then in_stall follows out_stall.
module boost_hysteresis_controller_core
  import bhc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // tick input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LOAD_W-1:0]     focused_load,
  input  logic [ID_W-1:0]       focused_id,
  input  logic                  on_mains,
  input  logic                  boost_allowed,
  input  logic [LEVEL_W-1:0]    display_level,
  input  logic                  display_level_ok,
  input  logic [LEVEL_W-1:0]    keyboard_level,
  input  logic                  keyboard_level_ok,
  input  logic [KHZ_W-1:0]      current_cap_khz,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  boosted,
  output logic [1:0]            transition,
  output logic                  cap_write,
  output logic [KHZ_W-1:0]      cap_khz,
  output logic                  keyboard_write,
  output logic [LEVEL_W-1:0]    keyboard_value,
  output logic                  display_write,
  output logic [LEVEL_W-1:0]    display_value,
  output logic                  display_dimmed,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  logic    cfg_busy;
  item_t   in_item;
  item_t   tick;        // input register
  logic    tick_valid;
  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t res;         // result register
  logic    out_free;
  logic    fire;
  logic    in_take;

  assign cfg_ready = 1'b1;

  bhc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .busy     (cfg_busy)
  );

  always_comb begin
    in_item.focused_load      = focused_load;
    in_item.focused_id        = focused_id;
    in_item.on_mains          = on_mains;
    in_item.boost_allowed     = boost_allowed;
    in_item.display_level     = display_level;
    in_item.display_level_ok  = display_level_ok;
    in_item.keyboard_level    = keyboard_level;
    in_item.keyboard_level_ok = keyboard_level_ok;
    in_item.current_cap_khz   = current_cap_khz;
  end

  // the tick in the input register is processed when the result register
  // can take it and no derived config value is in flight
  assign out_free = !out_valid || !out_stall;
  assign fire     = tick_valid && out_free && !cfg_busy;
  assign in_stall = tick_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  bhc_step u_step (
    .item    (tick),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      out_valid  <= 1'b0;
      st         <= '0;
    end else begin
      if (in_take) begin
        tick_valid <= 1'b1;
      end else if (fire) begin
        tick_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      tick <= in_item;
    end
    if (fire) begin
      res <= res_next;
    end
  end

  assign boosted        = res.boosted;
  assign transition     = res.transition;
  assign cap_write      = res.cap_write;
  assign cap_khz        = res.cap_khz;
  assign keyboard_write = res.keyboard_write;
  assign keyboard_value = res.keyboard_value;
  assign display_write  = res.display_write;
  assign display_value  = res.display_value;
  assign display_dimmed = res.display_dimmed;

`ifndef NO_ASSERTIONS
  // entering boost leaves the block boosted
  a_enter_boosted: assert property (@(posedge clk) disable iff (rst)
    out_valid && transition == TR_ENTER |-> boosted)
    else $error("enter beat without boost");

  // leaving boost drops both boost and dimming
  a_leave_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && transition == TR_LEAVE |-> !boosted && !display_dimmed)
    else $error("leave beat still boosted or dimmed");

  // dimming is only ever held under boost
  a_dim_in_boost: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_dimmed |-> boosted)
    else $error("display dimmed outside boost");

  // no tick is processed while the scaler is still deriving
  a_no_fire_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_busy |=> $stable(st))
    else $error("state moved while config derivation pending");

  // the cap value stays zero without a cap write
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cap_write |-> cap_khz == '0)
    else $error("cap value without cap write");
`endif

endmodule

// ----- hw/rtl/bhc_cfg_regs.sv -----
// bhc_cfg_regs: configuration register file with a two-stage scaler that
// derives the display dim target and the battery boost cap. Uses bhc_pkg.
module bhc_cfg_regs
  import bhc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg,
  output logic                  busy
);

  logic                  scale_valid;
  logic                  scale_is_disp;
  logic [PROD_W-1:0]     scale_prod;
  logic [SCALED_W-1:0]   scaled;
  logic [KHZ_W-1:0]      quot;
  logic                  derive_req;
  logic [PCT_W-1:0]      pct_sel;
  logic [KHZ_W-1:0]      scale_src;

  assign derive_req = wr_en && (wr_index == REG_TOP_FREQ || wr_index == REG_DISPLAY_MAX);
  assign pct_sel    = (wr_index == REG_DISPLAY_MAX) ? DISPLAY_PCT : BATTERY_PCT;
  assign scale_src  = (wr_index == REG_DISPLAY_MAX) ?
                      {{(KHZ_W-LEVEL_W){1'b0}}, wr_data[LEVEL_W-1:0]} : wr_data[KHZ_W-1:0];

  // second stage: divide by the percent base via reciprocal
  assign scaled = SCALED_W'(scale_prod) * SCALED_W'(RECIP);
  assign quot   = scaled[RECIP_SHIFT +: KHZ_W];
  assign busy   = scale_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_mains      <= THR_MAINS_RST;
      cfg.threshold_battery    <= THR_BATTERY_RST;
      cfg.display_max_level    <= '0;
      cfg.mains_boost_khz      <= MAINS_BOOST_RST;
      cfg.mains_baseline_khz   <= '0;
      cfg.battery_baseline_khz <= '0;
      cfg.keyboard_present     <= 1'b0;
      cfg.display_target       <= LEVEL_W'(1);
      cfg.battery_cap_khz      <= '0;
      scale_valid              <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_THR_MAINS:    cfg.threshold_mains      <= wr_data[THR_W-1:0];
          REG_THR_BATTERY:  cfg.threshold_battery    <= wr_data[THR_W-1:0];
          REG_TOP_FREQ:     ;
          REG_DISPLAY_MAX:  cfg.display_max_level    <= wr_data[LEVEL_W-1:0];
          REG_MAINS_BOOST:  cfg.mains_boost_khz      <= wr_data[KHZ_W-1:0];
          REG_MAINS_BASE:   cfg.mains_baseline_khz   <= wr_data[KHZ_W-1:0];
          REG_BATTERY_BASE: cfg.battery_baseline_khz <= wr_data[KHZ_W-1:0];
          REG_KBD_PRESENT:  cfg.keyboard_present     <= wr_data[0];
          default:          ;
        endcase
      end
      scale_valid <= derive_req;
      if (scale_valid) begin
        if (scale_is_disp) begin
          cfg.display_target <= (quot[LEVEL_W-1:0] == '0) ? LEVEL_W'(1) : quot[LEVEL_W-1:0];
        end else begin
          cfg.battery_cap_khz <= quot;
        end
      end
    end
  end

  // first stage: value times percent
  always_ff @(posedge clk) begin
    if (derive_req) begin
      scale_prod    <= PROD_W'(scale_src) * PROD_W'(pct_sel);
      scale_is_disp <= (wr_index == REG_DISPLAY_MAX);
    end
  end

endmodule

// ----- hw/rtl/bhc_step.sv -----
// bhc_step: per-tick decision logic, entry and exit of boost, writes to
// cap, keyboard and display. Purely combinational. Uses bhc_pkg.
module bhc_step
  import bhc_pkg::*;
(
  input  item_t   item,
  input  state_t  st,
  input  cfg_t    cfg,
  output state_t  st_next,
  output result_t res
);

  logic [THR_W-1:0]  thresh;
  logic [LOAD_W:0]   load_hyst;
  logic              enter_hit;
  logic              exit_hit;
  logic [KHZ_W-1:0]  base_khz;

  assign thresh    = item.on_mains ? cfg.threshold_mains : cfg.threshold_battery;
  assign load_hyst = {1'b0, item.focused_load} + HYST_TENTHS;
  assign enter_hit = item.boost_allowed &&
                     (item.focused_load >= {{(LOAD_W-THR_W){1'b0}}, thresh});
  assign exit_hit  = !item.boost_allowed ||
                     (load_hyst < {{(LOAD_W+1-THR_W){1'b0}}, thresh}) ||
                     (item.focused_id != st.boost_owner) ||
                     (item.on_mains != st.entered_on_mains);
  assign base_khz  = st.entered_on_mains ? cfg.mains_baseline_khz : cfg.battery_baseline_khz;

  always_comb begin
    st_next            = st;
    res.transition     = TR_NONE;
    res.cap_write      = 1'b0;
    res.cap_khz        = '0;
    res.keyboard_write = 1'b0;
    res.keyboard_value = '0;
    res.display_write  = 1'b0;
    res.display_value  = '0;

    if (!st.boost_on) begin
      // track user levels while idle
      if (item.display_level_ok) begin
        st_next.saved_display    = item.display_level;
        st_next.saved_display_ok = 1'b1;
      end
      if (item.keyboard_level_ok) begin
        st_next.saved_keyboard    = item.keyboard_level;
        st_next.saved_keyboard_ok = 1'b1;
      end
      if (enter_hit) begin
        st_next.entered_on_mains = item.on_mains;
        st_next.dim_active       = 1'b0;
        if (item.on_mains) begin
          st_next.boost_cap_khz = cfg.mains_boost_khz;
        end else begin
          res.keyboard_write = cfg.keyboard_present;
          // dim only a display brighter than the target
          if (cfg.display_max_level != '0 && st_next.saved_display_ok &&
              st_next.saved_display > cfg.display_target) begin
            st_next.dim_active = 1'b1;
            res.display_write  = 1'b1;
            res.display_value  = cfg.display_target;
          end
          st_next.boost_cap_khz = cfg.battery_cap_khz;
        end
        res.cap_write       = 1'b1;
        res.cap_khz         = st_next.boost_cap_khz;
        st_next.boost_owner = item.focused_id;
        st_next.boost_on    = 1'b1;
        res.transition      = TR_ENTER;
      end
    end else if (exit_hit) begin
      // cap restored only if nobody else moved it
      if (item.current_cap_khz == st.boost_cap_khz) begin
        res.cap_write = 1'b1;
        res.cap_khz   = base_khz;
      end
      if (!st.entered_on_mains) begin
        if (cfg.keyboard_present && st.saved_keyboard_ok) begin
          res.keyboard_write = 1'b1;
          res.keyboard_value = st.saved_keyboard;
        end
        if (st.dim_active && st.saved_display_ok) begin
          res.display_write = 1'b1;
          res.display_value = st.saved_display;
        end
      end
      st_next.dim_active = 1'b0;
      st_next.boost_on   = 1'b0;
      res.transition     = TR_LEAVE;
    end

    res.boosted        = st_next.boost_on;
    res.display_dimmed = st_next.dim_active;
  end

endmodule

// ----- sim/boost_hysteresis_controller_core_test.sv -----
// Self-checking bench for boost_hysteresis_controller_core: a directed plan, then
// randomised phases under several register settings, checked beat by beat.
// Depends on bhc_pkg and the RTL of the controller core only.
module boost_hysteresis_controller_core_test;
  import bhc_pkg::*;

  // Run limits and knobs
  localparam int CYCLE_LIMIT = 250000;  // far above the slowest legal run
  localparam int HOLD_CYCLES = 120;     // long output hold-off, fills the pipe
  localparam int REPORT_MAX  = 10;
  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 118;
  localparam int DRAIN_CYCLES = 8;      // input and result registers plus margin

  // Indexes past the end of the register map: writes there are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {STYLE_RANDOM, STYLE_ZERO, STYLE_FULL} phase_style_t;

  // One line of the directed plan: a tick beat (optionally with a hand-written
  // expected result) or a register write
  typedef struct packed {
    row_kind_t             op;
    item_t                 tick;
    logic                  typed;
    result_t               want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } plan_row_t;

  // ---------------------------------------------------------------------------
  // DUT connections
  // ---------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [LOAD_W-1:0]     focused_load;
  logic [ID_W-1:0]       focused_id;
  logic                  on_mains;
  logic                  boost_allowed;
  logic [LEVEL_W-1:0]    display_level;
  logic                  display_level_ok;
  logic [LEVEL_W-1:0]    keyboard_level;
  logic                  keyboard_level_ok;
  logic [KHZ_W-1:0]      current_cap_khz;
  logic                  out_valid;
  logic                  out_stall;
  logic                  boosted;
  logic [1:0]            transition;
  logic                  cap_write;
  logic [KHZ_W-1:0]      cap_khz;
  logic                  keyboard_write;
  logic [LEVEL_W-1:0]    keyboard_value;
  logic                  display_write;
  logic [LEVEL_W-1:0]    display_value;
  logic                  display_dimmed;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  boost_hysteresis_controller_core i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .focused_load      (focused_load),
    .focused_id        (focused_id),
    .on_mains          (on_mains),
    .boost_allowed     (boost_allowed),
    .display_level     (display_level),
    .display_level_ok  (display_level_ok),
    .keyboard_level    (keyboard_level),
    .keyboard_level_ok (keyboard_level_ok),
    .current_cap_khz   (current_cap_khz),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .boosted           (boosted),
    .transition        (transition),
    .cap_write         (cap_write),
    .cap_khz           (cap_khz),
    .keyboard_write    (keyboard_write),
    .keyboard_value    (keyboard_value),
    .display_write     (display_write),
    .display_value     (display_value),
    .display_dimmed    (display_dimmed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  // Mirror of the register file
  logic [THR_W-1:0]   m_thr_mains, m_thr_battery;
  logic [KHZ_W-1:0]   m_top_freq, m_mains_boost, m_mains_base, m_battery_base;
  logic [LEVEL_W-1:0] m_disp_max;
  logic               m_kbd_present;

  // Mirror of the controller state
  logic               s_boost, s_from_mains, s_disp_ok, s_kbd_ok, s_dim;
  logic [ID_W-1:0]    s_owner;
  logic [LEVEL_W-1:0] s_disp, s_kbd;
  logic [KHZ_W-1:0]   s_cap;

  result_t   pending_results[$];   // expected result beats, oldest first
  plan_row_t plan[$];

  // Random sequence context: runs of one focused task on one power source
  logic [ID_W-1:0] cur_id;
  logic            cur_mains;

  int  gap_odds;        // chance in eighths of a sender gap before a beat
  bit  calm;            // no idling on either side
  bit  hold_req;        // asks the receiver for one long hold-off
  int  cycles, checked, mismatches, ticks_sent, directed_ticks, settings;
  int  entries, exits, dims, holds, pauses;

  // ---------------------------------------------------------------------------
  // Clock and cycle guard
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic reset_mirror();
    m_thr_mains    = THR_MAINS_RST;
    m_thr_battery  = THR_BATTERY_RST;
    m_top_freq     = '0;
    m_disp_max     = '0;
    m_mains_boost  = MAINS_BOOST_RST;
    m_mains_base   = '0;
    m_battery_base = '0;
    m_kbd_present  = 1'b0;
    s_boost        = 1'b0;
    s_from_mains   = 1'b0;
    s_owner        = '0;
    s_disp         = '0;
    s_disp_ok      = 1'b0;
    s_kbd          = '0;
    s_kbd_ok       = 1'b0;
    s_dim          = 1'b0;
    s_cap          = '0;
  endtask

  task automatic mirror_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_THR_MAINS:    m_thr_mains    = data[THR_W-1:0];
      REG_THR_BATTERY:  m_thr_battery  = data[THR_W-1:0];
      REG_TOP_FREQ:     m_top_freq     = data[KHZ_W-1:0];
      REG_DISPLAY_MAX:  m_disp_max     = data[LEVEL_W-1:0];
      REG_MAINS_BOOST:  m_mains_boost  = data[KHZ_W-1:0];
      REG_MAINS_BASE:   m_mains_base   = data[KHZ_W-1:0];
      REG_BATTERY_BASE: m_battery_base = data[KHZ_W-1:0];
      REG_KBD_PRESENT:  m_kbd_present  = data[0];
      default: ;  // unmapped index, nothing changes
    endcase
  endtask

  // One tick through the boost state machine; updates the mirrored state
  task automatic step_controller(input item_t t, output result_t r);
    logic [THR_W-1:0] thr;
    int               target;
    longint           scaled;
    r   = '0;
    thr = t.on_mains ? m_thr_mains : m_thr_battery;
    if (!s_boost) begin
      // idle: keep tracking the user's levels
      if (t.display_level_ok) begin
        s_disp    = t.display_level;
        s_disp_ok = 1'b1;
      end
      if (t.keyboard_level_ok) begin
        s_kbd    = t.keyboard_level;
        s_kbd_ok = 1'b1;
      end
      if (t.boost_allowed && t.focused_load >= thr) begin
        s_from_mains = t.on_mains;
        s_dim        = 1'b0;
        if (t.on_mains) begin
          s_cap = m_mains_boost;
        end else begin
          if (m_kbd_present) begin
            r.keyboard_write = 1'b1;
            r.keyboard_value = '0;
          end
          if (m_disp_max != 0) begin
            target = int'(m_disp_max) * DISPLAY_PERCENT / PCT_BASE;
            if (target < 1) target = 1;
            if (s_disp_ok && int'(s_disp) > target) begin
              s_dim           = 1'b1;
              r.display_write = 1'b1;
              r.display_value = LEVEL_W'(target);
            end
          end
          scaled = longint'(m_top_freq) * BATTERY_FREQ_PERCENT / PCT_BASE;
          s_cap  = KHZ_W'(scaled);
        end
        r.cap_write  = 1'b1;
        r.cap_khz    = s_cap;
        s_owner      = t.focused_id;
        s_boost      = 1'b1;
        r.transition = TR_ENTER;
      end
    end else if (!t.boost_allowed ||
                 int'(t.focused_load) + int'(HYST_TENTHS) < int'(thr) ||
                 t.focused_id != s_owner || t.on_mains != s_from_mains) begin
      // leave boost; the cap goes back only if nobody else moved it
      if (t.current_cap_khz == s_cap) begin
        r.cap_write = 1'b1;
        r.cap_khz   = s_from_mains ? m_mains_base : m_battery_base;
      end
      if (!s_from_mains) begin
        if (m_kbd_present && s_kbd_ok) begin
          r.keyboard_write = 1'b1;
          r.keyboard_value = s_kbd;
        end
        if (s_dim && s_disp_ok) begin
          r.display_write = 1'b1;
          r.display_value = s_disp;
        end
      end
      s_dim        = 1'b0;
      s_boost      = 1'b0;
      r.transition = TR_LEAVE;
    end
    r.boosted        = s_boost;
    r.display_dimmed = s_dim;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t tk(input int unsigned load, input int unsigned id,
                               input bit mains, input bit allowed,
                               input int unsigned disp, input bit dok,
                               input int unsigned kbd, input bit kok,
                               input int unsigned cap);
    item_t t;
    t.focused_load      = LOAD_W'(load);
    t.focused_id        = ID_W'(id);
    t.on_mains          = mains;
    t.boost_allowed     = allowed;
    t.display_level     = LEVEL_W'(disp);
    t.display_level_ok  = dok;
    t.keyboard_level    = LEVEL_W'(kbd);
    t.keyboard_level_ok = kok;
    t.current_cap_khz   = KHZ_W'(cap);
    return t;
  endfunction

  function automatic result_t rs(input bit bst, input trans_t tr,
                                 input bit cw, input int unsigned cap,
                                 input bit kw, input int unsigned kv,
                                 input bit dw, input int unsigned dv, input bit dim);
    result_t r;
    r.boosted        = bst;
    r.transition     = tr;
    r.cap_write      = cw;
    r.cap_khz        = KHZ_W'(cap);
    r.keyboard_write = kw;
    r.keyboard_value = LEVEL_W'(kv);
    r.display_write  = dw;
    r.display_value  = LEVEL_W'(dv);
    r.display_dimmed = dim;
    return r;
  endfunction

  function automatic void add_tick(input item_t t, input bit typed, input result_t want);
    plan_row_t row;
    row       = '0;
    row.op    = ROW_TICK;
    row.tick  = t;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row      = '0;
    row.op   = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    plan.push_back(row);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] r);
    case (r)
      REG_THR_MAINS, REG_THR_BATTERY:
        return ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom)
                                           : CFG_DATA_W'($urandom_range(100, 10000));
      REG_DISPLAY_MAX:
        return ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 4))
                                           : CFG_DATA_W'($urandom);
      default:
        return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed runs: one task, one source, load hovering around the
  // live threshold; with some noise that breaks runs up
  function automatic item_t next_tick();
    item_t t;
    int    thr, ld;
    if ($urandom_range(0, 24) == 0) cur_id = ID_W'($urandom);
    if ($urandom_range(0, 29) == 0) cur_mains = ~cur_mains;
    thr = cur_mains ? int'(m_thr_mains) : int'(m_thr_battery);
    case ($urandom_range(0, 9))
      0:       ld = $urandom_range(0, 1) ? 0 : 65535;
      1, 2:    ld = int'($urandom_range(0, 65535));
      default: ld = thr + int'($urandom_range(0, 300)) - 150;
    endcase
    if (ld < 0) ld = 0;
    if (ld > 65535) ld = 65535;
    t.focused_load      = LOAD_W'(ld);
    t.focused_id        = ($urandom_range(0, 19) == 0) ? ID_W'($urandom) : cur_id;
    t.on_mains          = ($urandom_range(0, 39) == 0) ? ~cur_mains : cur_mains;
    t.boost_allowed     = ($urandom_range(0, 19) != 0);
    t.display_level     = LEVEL_W'($urandom);
    t.display_level_ok  = ($urandom_range(0, 4) != 0);
    t.keyboard_level    = LEVEL_W'($urandom);
    t.keyboard_level_ok = ($urandom_range(0, 4) != 0);
    // while boosted, usually report the boost cap still in force
    t.current_cap_khz   = (s_boost && $urandom_range(0, 3) != 0) ? s_cap
                                                                 : KHZ_W'($urandom);
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------
  // Offer one tick beat; in_valid stays high on return
  task automatic offer_tick(input item_t t, input bit typed, input result_t want);
    result_t pred;
    focused_load      <= t.focused_load;
    focused_id        <= t.focused_id;
    on_mains          <= t.on_mains;
    boost_allowed     <= t.boost_allowed;
    display_level     <= t.display_level;
    display_level_ok  <= t.display_level_ok;
    keyboard_level    <= t.keyboard_level;
    keyboard_level_ok <= t.keyboard_level_ok;
    current_cap_khz   <= t.current_cap_khz;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall);
    step_controller(t, pred);
    pending_results.push_back(typed ? want : pred);
    ticks_sent++;
    if (pred.transition == TR_ENTER) entries++;
    if (pred.transition == TR_LEAVE) exits++;
    if (pred.display_write && pred.transition == TR_ENTER) dims++;
  endtask

  task automatic sender_gap();
    if (!calm && gap_odds > 0 && $urandom_range(0, 7) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result beat
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // cfg_valid is left high so back-to-back writes need no dip
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    mirror_reg_write(idx, data);
  endtask

  task automatic program_phase(input phase_style_t style);
    logic [CFG_DATA_W-1:0] v;
    for (int r = int'(REG_THR_MAINS); r <= int'(REG_KBD_PRESENT); r++) begin
      case (style)
        STYLE_ZERO: v = '0;
        STYLE_FULL: v = '1;
        default:    v = pick_reg_value(CFG_IDX_W'(r));
      endcase
      program_reg(CFG_IDX_W'(r), v);
    end
    program_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, none when calm.
  // Each pass drives out_stall once and holds it until its randomly drawn wait ends.
  // ---------------------------------------------------------------------------
  initial begin : out_stall_drive
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holds++;
        n = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1'b1;
      end else begin
        n = $urandom_range(1, 30);
        out_stall <= 1'b0;
      end
      repeat (n) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.boosted        = boosted;
      got.transition     = trans_t'(transition);
      got.cap_write      = cap_write;
      got.cap_khz        = cap_khz;
      got.keyboard_write = keyboard_write;
      got.keyboard_value = keyboard_value;
      got.display_write  = display_write;
      got.display_value  = display_value;
      got.display_dimmed = display_dimmed;
      if (pending_results.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("beat %0d: result arrived with nothing expected", checked);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.boosted !== want.boosted || got.transition !== want.transition ||
            got.cap_write !== want.cap_write || got.cap_khz !== want.cap_khz ||
            got.keyboard_write !== want.keyboard_write ||
            got.keyboard_value !== want.keyboard_value ||
            got.display_write !== want.display_write ||
            got.display_value !== want.display_value ||
            got.display_dimmed !== want.display_dimmed) begin
          if (mismatches < REPORT_MAX) begin
            $display("beat %0d mismatch (exp/got): boosted %0b/%0b tr %0d/%0d",
                     checked, want.boosted, got.boosted, want.transition, got.transition);
            $display("  cap %0b:%0h/%0b:%0h kbd %0b:%0h/%0b:%0h",
                     want.cap_write, want.cap_khz, got.cap_write, got.cap_khz,
                     want.keyboard_write, want.keyboard_value,
                     got.keyboard_write, got.keyboard_value);
            $display("  disp %0b:%0h/%0b:%0h dimmed %0b/%0b",
                     want.display_write, want.display_value,
                     got.display_write, got.display_value,
                     want.display_dimmed, got.display_dimmed);
          end
          mismatches++;
        end
      end
      checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    bit cfg_open;
    // every input known from time zero
    rst               <= 1'b1;
    in_valid          <= 1'b0;
    focused_load      <= '0;
    focused_id        <= '0;
    on_mains          <= 1'b0;
    boost_allowed     <= 1'b0;
    display_level     <= '0;
    display_level_ok  <= 1'b0;
    keyboard_level    <= '0;
    keyboard_level_ok <= 1'b0;
    current_cap_khz   <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    cycles = 0; checked = 0; mismatches = 0; ticks_sent = 0; settings = 1;
    entries = 0; exits = 0; dims = 0; holds = 0; pauses = 0;
    gap_odds = 0; calm = 1'b0; hold_req = 1'b0; cfg_open = 1'b0;
    cur_id = '0; cur_mains = 1'b0;
    reset_mirror();

    // Directed plan. Rows with a typed result are the obvious ones.
    // straight out of reset: idle, nothing written
    add_tick(tk(0, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1, rs(0, TR_NONE, 0, 0, 0, 0, 0, 0, 0));
    add_tick(tk(799, 1, 0, 1, 0, 0, 0, 0, 0), 1'b1, rs(0, TR_NONE, 0, 0, 0, 0, 0, 0, 0));
    add_reg(REG_DISPLAY_MAX, 24'hFFFFFF);
    add_reg(REG_KBD_PRESENT, 24'h000001);
    add_reg(REG_TOP_FREQ, 24'hFFFFFF);
    add_reg(REG_BATTERY_BASE, 24'h123456);
    add_reg(REG_MAINS_BASE, 24'hABCDEF);
    add_reg(REG_SPARE_LO, 24'hFFFFFF);     // ignored
    add_reg(REG_SPARE_HI, 24'h000000);     // ignored
    // battery boost with no levels saved yet: keyboard off, no dimming
    add_tick(tk(800, 1, 0, 1, 0, 0, 0, 0, 0), 1'b0, '0);
    // boost withdrawn: keyboard not restored since never saved
    add_tick(tk(65535, 1, 0, 0, 65535, 1, 65535, 1, 8388607), 1'b0, '0);
    // mains boost at the field extremes, hold, drop out on load
    add_tick(tk(65535, 22'h3FFFFF, 1, 1, 65535, 1, 65535, 1, 24'hFFFFFF), 1'b1,
             rs(1, TR_ENTER, 1, 2600000, 0, 0, 0, 0, 0));
    add_tick(tk(65535, 22'h3FFFFF, 1, 1, 65535, 1, 65535, 1, 2600000), 1'b1,
             rs(1, TR_NONE, 0, 0, 0, 0, 0, 0, 0));
    add_tick(tk(0, 22'h3FFFFF, 1, 1, 0, 1, 0, 1, 2600000), 1'b1,
             rs(0, TR_LEAVE, 1, 24'hABCDEF, 0, 0, 0, 0, 0));
    // battery boost that dims a bright display, then load exit restores both
    add_tick(tk(800, 2, 0, 1, 65535, 1, 0, 1, 0), 1'b0, '0);
    add_tick(tk(699, 2, 0, 1, 0, 0, 0, 0, 8388607), 1'b0, '0);
    add_reg(REG_DISPLAY_MAX, 24'h000003);  // target rounds to zero, raised to one
    add_reg(REG_MAINS_BOOST, 24'hFFFFFF);
    add_tick(tk(800, 6, 0, 1, 2, 1, 7, 1, 0), 1'b0, '0);
    add_tick(tk(700, 6, 0, 1, 0, 0, 0, 0, 8388607), 1'b0, '0);
    // power flips with the cap moved elsewhere: levels back, cap left alone
    add_tick(tk(1000, 6, 1, 1, 0, 0, 0, 0, 5), 1'b0, '0);
    add_tick(tk(65535, 9, 1, 0, 0, 0, 0, 0, 0), 1'b1, rs(0, TR_NONE, 0, 0, 0, 0, 0, 0, 0));
    add_reg(REG_THR_BATTERY, 24'd100);     // at the hysteresis, load never exits
    add_reg(REG_DISPLAY_MAX, 24'h000000);  // no display control
    add_reg(REG_KBD_PRESENT, 24'h000000);  // no keyboard
    add_reg(REG_THR_MAINS, 24'hFFFFFF);    // masks to the top threshold
    add_tick(tk(100, 4, 0, 1, 500, 1, 9, 1, 0), 1'b0, '0);
    add_tick(tk(0, 4, 0, 1, 0, 0, 0, 0, 8388607), 1'b0, '0);
    add_tick(tk(0, 5, 0, 1, 0, 0, 0, 0, 8388607), 1'b0, '0);   // focus change
    add_tick(tk(16382, 1, 1, 1, 0, 0, 0, 0, 0), 1'b0, '0);
    add_tick(tk(16383, 1, 1, 1, 0, 0, 0, 0, 0), 1'b0, '0);
    add_tick(tk(16283, 1, 1, 1, 0, 0, 0, 0, 24'hFFFFFF), 1'b0, '0);
    add_tick(tk(16282, 1, 1, 1, 0, 0, 0, 0, 24'hFFFFFF), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) begin
        if (!cfg_open) settle();  // registers only change with the block idle
        cfg_open = 1'b1;
        program_reg(plan[i].idx, plan[i].data);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
          settings++;
        end
        offer_tick(plan[i].tick, plan[i].typed, plan[i].want);
      end
    end
    directed_ticks = ticks_sent;

    // Random phases. Phase 1 has every register at zero, phase 3 at all ones.
    // Phase 2 offers back to back while the receiver holds off; phase 4 has a
    // full pause mid-way; the last phase runs with no idling at all.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      program_phase(p == 1 ? STYLE_ZERO : (p == 3 ? STYLE_FULL : STYLE_RANDOM));
      gap_odds = (p == 2) ? 0 : (p % 4) + 1;
      calm     = (p == PHASES - 1);
      cur_id    = ID_W'($urandom);
      cur_mains = 1'($urandom_range(0, 1));
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (p == 2 && n == 20) hold_req = 1'b1;
        if (p == 4 && n == 60) begin
          settle();
          pauses++;
        end
        sender_gap();
        offer_tick(next_tick(), 1'b0, '0);
      end
    end

    // wind down: everything back, then a few spare cycles for strays
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d ticks (%0d directed) under %0d register settings, %0d results checked",
             ticks_sent, directed_ticks, settings, checked);
    $display("boost entered %0d, left %0d, dimmed %0d; %0d long hold-off, %0d pause",
             entries, exits, dims, holds, pauses);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatching beats", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
